>>> rtl/dot_product_top_k_ranker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ranker
// Clocked, reset-gated property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef DOT_PRODUCT_TOP_K_RANKER_ASSERT_SVH
`define DOT_PRODUCT_TOP_K_RANKER_ASSERT_SVH

// same-cycle implication
`define DPR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared widths, codes and types of the dot product top-k ranker.
// ----------------------------------------------------------------------------
package dpr_pkg;

  localparam int VECTOR_MAX_DEF  = 64;
  localparam int EXCLUDE_MAX_DEF = 64;
  localparam int TOPK_MAX_DEF    = 16;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = 6;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SCORE_W = 38;
  localparam int RANK_W  = 4;
  localparam int TOPK_W  = 5;
  localparam int VLEN_W  = 7;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_K = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VLEN  = 1'b1;

  localparam logic [TOPK_W-1:0] TOP_K_RST = 5'd10;
  localparam logic [VLEN_W-1:0] VLEN_RST  = 7'd64;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_USER   = 2'd0,
    FUNC_EXCL   = 2'd1,
    FUNC_CAND   = 2'd2,
    FUNC_FINISH = 2'd3
  } dpr_func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SCAN,
    S_INSERT,
    S_EMIT
  } dpr_state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_CLEAR
  } dpr_op_e;

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [KEY_W-1:0]          id;
  } dpr_entry_t;

endpackage

>>> rtl/dot_product_top_k_ranker.sv
// ----------------------------------------------------------------------------
// dot_product_top_k_ranker
// Scores candidates against a stored user vector, keeps a sorted top-k chain.
// ----------------------------------------------------------------------------
// User and excluded-id beats are taken in idle. A candidate element goes
// through the multiply and accumulate states; one with an index past the
// vector length is dropped. A closing element then scans the exclusion
// memory one entry per cycle and is inserted unless its id is excluded.
// Finish: results come out of the cell chain one per cycle; busy drops with
// the last one. Reset clears control, counters and chain valid bits and sets
// the settings to defaults; memories keep content. Results cannot be stalled.
module dot_product_top_k_ranker
  import dpr_pkg::*;
#(
  parameter int VECTOR_MAX  = VECTOR_MAX_DEF,
  parameter int EXCLUDE_MAX = EXCLUDE_MAX_DEF,
  parameter int TOPK_MAX    = TOPK_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                func_i,
  input  logic [KEY_W-1:0]          item_key_i,
  input  logic signed [VAL_W-1:0]   element_value_i,
  input  logic [IDX_W-1:0]          element_index_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output logic                      result_valid_o,
  output logic [KEY_W-1:0]          result_id_o,
  output logic signed [SCORE_W-1:0] result_score_o,
  output logic [RANK_W-1:0]         rank_o,
  output logic                      found_o,
  output logic                      exclusion_overflow_o,
  output logic                      last_o
);

  localparam int VAW  = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
  localparam int XAW  = (EXCLUDE_MAX > 1) ? $clog2(EXCLUDE_MAX) : 1;
  localparam int XCW  = $clog2(EXCLUDE_MAX + 1);
  localparam int LENW = ($clog2(VECTOR_MAX + 1) > VLEN_W) ? $clog2(VECTOR_MAX + 1) : VLEN_W;
  localparam int KW   = ($clog2(TOPK_MAX + 1) > TOPK_W) ? $clog2(TOPK_MAX + 1) : TOPK_W;

  dpr_state_e state_q, state_d;
  dpr_func_e  func;
  dpr_op_e    chain_op;

  logic accept, user_we, excl_we, in_range, closing, last_w, scan_more;

  // configuration
  logic [TOPK_W-1:0] top_k_q;
  logic [VLEN_W-1:0] vlen_q;
  logic [LENW-1:0]   len_used, idx_ext;
  logic [KW-1:0]     k_used;

  // memories
  logic signed [VAL_W-1:0] user_mem [VECTOR_MAX];
  logic signed [VAL_W-1:0] user_rd_q;
  logic [VAW+IDX_W-1:0]    idx_wide;
  logic [KEY_W-1:0]        excl_mem [EXCLUDE_MAX];
  logic [KEY_W-1:0]        excl_rd_q;

  // control registers
  logic [XCW-1:0] excl_cnt_q, excl_cnt_d;
  logic           ovf_q, ovf_d;
  logic [XCW-1:0] scan_ptr_q, scan_ptr_d;
  logic           scan_rdv_q, scan_rdv_d;
  logic           hit_q, hit_d;
  logic [KW-1:0]  emit_cnt_q, emit_cnt_d;
  logic           res_valid_q;
  logic signed [SCORE_W-1:0] acc_q, acc_d;

  // payload registers
  logic signed [VAL_W-1:0]   val_q;
  logic [KEY_W-1:0]          key_q;
  logic                      closing_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SCORE_W-1:0] cand_score_q;
  logic signed [SCORE_W:0]   sum_w;
  logic signed [SCORE_W-1:0] sat_w;
  logic [KEY_W-1:0]          res_id_q;
  logic signed [SCORE_W-1:0] res_score_q;
  logic [RANK_W-1:0]         res_rank_q;
  logic                      res_found_q, res_ovf_q, res_last_q;
  logic [KW+RANK_W-1:0]      rank_wide;

  // cell chain
  dpr_entry_t cell_w [TOPK_MAX];
  dpr_entry_t prev_w [TOPK_MAX];
  dpr_entry_t next_w [TOPK_MAX];
  logic       take_w [TOPK_MAX];
  logic       prev_take_w [TOPK_MAX];
  dpr_entry_t new_entry;

  assign func = dpr_func_e'(func_i);

  // ---- clamped configuration -------------------------------------------
  always_comb begin
    len_used = LENW'(vlen_q);
    if (vlen_q == '0) begin
      len_used = LENW'(1);
    end else if (LENW'(vlen_q) > LENW'(VECTOR_MAX)) begin
      len_used = LENW'(VECTOR_MAX);
    end
    k_used = KW'(top_k_q);
    if (top_k_q == '0) begin
      k_used = KW'(1);
    end else if (KW'(top_k_q) > KW'(TOPK_MAX)) begin
      k_used = KW'(TOPK_MAX);
    end
  end

  assign idx_ext  = LENW'(element_index_i);
  assign in_range = idx_ext < len_used;
  assign closing  = idx_ext == (len_used - LENW'(1));
  assign idx_wide = (VAW + IDX_W)'(element_index_i);

  // ---- memories ----------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (user_we) begin
      user_mem[idx_wide[VAW-1:0]] <= element_value_i;
    end
    user_rd_q <= user_mem[idx_wide[VAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (excl_we) begin
      excl_mem[excl_cnt_q[XAW-1:0]] <= item_key_i;
    end
    excl_rd_q <= excl_mem[scan_ptr_q[XAW-1:0]];
  end

  // ---- cell chain --------------------------------------------------------
  assign new_entry = '{valid: 1'b1, score: cand_score_q, id: key_q};

  for (genvar i = 0; i < TOPK_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_w[i]      = '0;
      assign prev_take_w[i] = 1'b0;
    end else begin : g_body
      assign prev_w[i]      = cell_w[i-1];
      assign prev_take_w[i] = take_w[i-1];
    end
    if (i == TOPK_MAX - 1) begin : g_tail
      assign next_w[i] = '0;
    end else begin : g_mid
      assign next_w[i] = cell_w[i+1];
    end

    dpr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (chain_op),
      .new_i       (new_entry),
      .prev_i      (prev_w[i]),
      .prev_take_i (prev_take_w[i]),
      .next_i      (next_w[i]),
      .own_o       (cell_w[i]),
      .take_o      (take_w[i])
    );
  end

  // ---- multiply-accumulate with saturation -------------------------------
  always_comb begin
    sum_w = (SCORE_W + 1)'(acc_q) + (SCORE_W + 1)'(prod_q);
    sat_w = sum_w[SCORE_W-1:0];
    if (sum_w[SCORE_W] != sum_w[SCORE_W-1]) begin
      sat_w = sum_w[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
  end

  assign scan_more = scan_ptr_q < excl_cnt_q;
  assign last_w    = !cell_w[0].valid || (emit_cnt_q == (k_used - KW'(1)))
                     || !next_w[0].valid;

  // ---- next state --------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_CAND:   if (in_range) state_d = S_MUL;
            FUNC_FINISH: state_d = S_EMIT;
            default: ;
          endcase
        end
      end
      S_MUL:    state_d = S_ACC;
      S_ACC:    state_d = closing_q ? S_SCAN : S_IDLE;
      S_SCAN: begin
        if (!scan_more && !scan_rdv_q) begin
          state_d = hit_q ? S_IDLE : S_INSERT;
        end
      end
      S_INSERT: state_d = S_IDLE;
      S_EMIT:   if (last_w) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---- state outputs -----------------------------------------------------
  always_comb begin
    busy_o   = state_q != S_IDLE;
    accept   = start_i && !busy_o;
    user_we  = accept && (func == FUNC_USER)
               && (idx_wide < (VAW + IDX_W)'(VECTOR_MAX));
    excl_we  = accept && (func == FUNC_EXCL) && (excl_cnt_q < XCW'(EXCLUDE_MAX));
    chain_op = OP_HOLD;
    case (state_q)
      S_INSERT: chain_op = OP_INSERT;
      S_EMIT:   chain_op = last_w ? OP_CLEAR : OP_SHIFT;
      default: ;
    endcase
  end

  // ---- control register updates ------------------------------------------
  always_comb begin
    excl_cnt_d = excl_cnt_q;
    ovf_d      = ovf_q;
    acc_d      = acc_q;
    scan_ptr_d = scan_ptr_q;
    scan_rdv_d = 1'b0;
    hit_d      = hit_q;
    emit_cnt_d = emit_cnt_q;
    if (excl_we) begin
      excl_cnt_d = excl_cnt_q + XCW'(1);
    end else if (accept && (func == FUNC_EXCL)) begin
      ovf_d = 1'b1;
    end
    if (accept && (func == FUNC_FINISH)) begin
      emit_cnt_d = '0;
    end
    case (state_q)
      S_ACC: begin
        acc_d      = closing_q ? '0 : sat_w;
        scan_ptr_d = '0;
        hit_d      = 1'b0;
      end
      S_SCAN: begin
        if (scan_more) begin
          scan_ptr_d = scan_ptr_q + XCW'(1);
        end
        scan_rdv_d = scan_more;
        hit_d      = hit_q || (scan_rdv_q && (excl_rd_q == key_q));
      end
      S_EMIT: begin
        emit_cnt_d = emit_cnt_q + KW'(1);
        if (last_w) begin
          excl_cnt_d = '0;
          ovf_d      = 1'b0;
          acc_d      = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_k_q     <= TOP_K_RST;
      vlen_q      <= VLEN_RST;
      excl_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      scan_ptr_q  <= '0;
      scan_rdv_q  <= 1'b0;
      hit_q       <= 1'b0;
      emit_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      excl_cnt_q  <= excl_cnt_d;
      ovf_q       <= ovf_d;
      acc_q       <= acc_d;
      scan_ptr_q  <= scan_ptr_d;
      scan_rdv_q  <= scan_rdv_d;
      hit_q       <= hit_d;
      emit_cnt_q  <= emit_cnt_d;
      res_valid_q <= state_q == S_EMIT;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOP_K: top_k_q <= cfg_data_i[TOPK_W-1:0];
          REG_VLEN:  vlen_q  <= cfg_data_i[VLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---- datapath payload --------------------------------------------------
  assign rank_wide = (KW + RANK_W)'(emit_cnt_q);

  always_ff @(posedge clk_i) begin
    if (accept && (func == FUNC_CAND)) begin
      val_q     <= element_value_i;
      key_q     <= item_key_i;
      closing_q <= closing;
    end
    if (state_q == S_MUL) begin
      prod_q <= val_q * user_rd_q;
    end
    if (state_q == S_ACC) begin
      cand_score_q <= sat_w;
    end
    if (state_q == S_EMIT) begin
      res_id_q    <= cell_w[0].valid ? cell_w[0].id : '0;
      res_score_q <= cell_w[0].valid ? cell_w[0].score : '0;
      res_rank_q  <= rank_wide[RANK_W-1:0];
      res_found_q <= cell_w[0].valid;
      res_ovf_q   <= ovf_q;
      res_last_q  <= last_w;
    end
  end

  assign result_valid_o       = res_valid_q;
  assign result_id_o          = res_id_q;
  assign result_score_o       = res_score_q;
  assign rank_o               = res_rank_q;
  assign found_o              = res_found_q;
  assign exclusion_overflow_o = res_ovf_q;
  assign last_o               = res_last_q;

endmodule

>>> rtl/dpr_cell.sv
// ----------------------------------------------------------------------------
// dpr_cell
// One slot of the sorted top-k chain: compares, inserts, shifts out.
// ----------------------------------------------------------------------------
module dpr_cell
  import dpr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dpr_op_e    op_i,
  input  dpr_entry_t new_i,
  input  dpr_entry_t prev_i,
  input  logic       prev_take_i,
  input  dpr_entry_t next_i,
  output dpr_entry_t own_o,
  output logic       take_o
);

  logic                      valid_q, valid_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [KEY_W-1:0]          id_q, id_d;

  // strictly greater: equal scores stay behind earlier arrivals
  assign take_o = !valid_q || ($signed(new_i.score) > $signed(score_q));
  assign own_o  = '{valid: valid_q, score: score_q, id: id_q};

  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    id_d    = id_q;
    case (op_i)
      OP_INSERT: begin
        if (take_o) begin
          if (prev_take_i) begin
            valid_d = prev_i.valid;
            score_d = prev_i.score;
            id_d    = prev_i.id;
          end else begin
            valid_d = 1'b1;
            score_d = new_i.score;
            id_d    = new_i.id;
          end
        end
      end
      OP_SHIFT: begin
        valid_d = next_i.valid;
        score_d = next_i.score;
        id_d    = next_i.id;
      end
      OP_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    id_q    <= id_d;
  end

endmodule

>>> rtl/dpr_checker.sv
// ----------------------------------------------------------------------------
// dpr_checker
// Port-level checks of the result sequence, bound to the ranker top level.
// ----------------------------------------------------------------------------
`include "dot_product_top_k_ranker_assert.svh"

module dpr_checker
  import dpr_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic [1:0]                func_i,
  input logic                      result_valid_o,
  input logic [KEY_W-1:0]          result_id_o,
  input logic signed [SCORE_W-1:0] result_score_o,
  input logic [RANK_W-1:0]         rank_o,
  input logic                      found_o,
  input logic                      last_o
);

  `DPR_ASSERT_NXT(a_finish_busy, start_i && !busy_o && (func_i == FUNC_FINISH), busy_o, "finish beat did not make the block busy")

  `DPR_ASSERT_IMP(a_empty_answer, result_valid_o && !found_o, last_o && (rank_o == '0) && (result_id_o == '0) && (result_score_o == '0), "empty answer is malformed")

  `DPR_ASSERT_IMP(a_last_idle, result_valid_o && last_o, !busy_o, "still busy after the last result")

  `DPR_ASSERT_NXT(a_rank_step, result_valid_o && !last_o, result_valid_o && found_o && (rank_o == RANK_W'($past(rank_o) + 1'b1)), "results not consecutive")

  `DPR_ASSERT_NXT(a_descending, result_valid_o && !last_o, $signed(result_score_o) <= $signed($past(result_score_o)), "scores not descending")

endmodule

bind dot_product_top_k_ranker dpr_checker u_dpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .func_i         (func_i),
  .result_valid_o (result_valid_o),
  .result_id_o    (result_id_o),
  .result_score_o (result_score_o),
  .rank_o         (rank_o),
  .found_o        (found_o),
  .last_o         (last_o)
);

>>> test/tb_dot_product_top_k_ranker.sv
// ----------------------------------------------------------------------------
// tb_dot_product_top_k_ranker
// Self-checking bench for the dot product top-k ranker. A scoreboard object
// keeps its own user vector, exclusion table, running score and sorted best
// list, and predicts the ranked beats of every finish. Stimulus is a short
// directed pass, a long accumulation that saturates the score, an exclusion
// table overflow, and random query mixes under several register settings.
// ----------------------------------------------------------------------------
module tb_dot_product_top_k_ranker;
  import dpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  SETTLE_CYCLES = 80;   // closing beat scans up to 64 excluded ids
  localparam int  SAT_BEATS     = 130;  // 130 products near -2^30 pass the 38-bit limit
  localparam int  USER_FILL     = 8;    // random mixes keep the length at or below this
  localparam longint SCORE_HI   = (longint'(1) <<< (SCORE_W - 1)) - 1;
  localparam longint SCORE_LO   = -SCORE_HI - 1;

  typedef struct packed {
    logic [KEY_W-1:0]   id;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  rank;
    logic               found;
    logic               ovf;
    logic               last;
  } ranked_t;

  class rank_board;
    logic signed [VAL_W-1:0] user_vec [VECTOR_MAX_DEF];
    logic [KEY_W-1:0]        excl_ids [$];
    bit                      excl_ovf;
    longint                  acc;
    longint                  best_score [$];
    logic [KEY_W-1:0]        best_id [$];
    logic [TOPK_W-1:0]       top_k_reg;
    logic [VLEN_W-1:0]       vlen_reg;
    ranked_t                 pending [$];
    int                      errors;
    int                      beats;
    int                      results;
    int                      queries;

    function new();
      top_k_reg = TOP_K_RST;
      vlen_reg  = VLEN_RST;
      clear_query();
    endfunction

    function void clear_query();
      excl_ids.delete();
      best_score.delete();
      best_id.delete();
      excl_ovf = 1'b0;
      acc      = 0;
    endfunction

    function int used_len();
      if (vlen_reg == 0) return 1;
      if (vlen_reg > VECTOR_MAX_DEF) return VECTOR_MAX_DEF;
      return vlen_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_TOP_K) top_k_reg = data[TOPK_W-1:0];
      else vlen_reg = data[VLEN_W-1:0];
    endfunction

    function bit is_excluded(logic [KEY_W-1:0] key);
      foreach (excl_ids[i]) if (excl_ids[i] == key) return 1'b1;
      return 1'b0;
    endfunction

    // equal scores land behind the ones already kept
    function void rank_insert(logic [KEY_W-1:0] id, longint score);
      int pos = 0;
      while (pos < best_score.size() && best_score[pos] >= score) pos++;
      if (pos >= TOPK_MAX_DEF) return;
      best_score.insert(pos, score);
      best_id.insert(pos, id);
      if (best_score.size() > TOPK_MAX_DEF) begin
        void'(best_score.pop_back());
        void'(best_id.pop_back());
      end
    endfunction

    function void note_beat(dpr_func_e f, logic [KEY_W-1:0] key,
                            logic signed [VAL_W-1:0] val, logic [IDX_W-1:0] idx);
      int      len;
      int      k;
      int      n;
      longint  sum;
      ranked_t e;
      beats++;
      case (f)
        FUNC_USER: user_vec[idx] = val;
        FUNC_EXCL: begin
          if (excl_ids.size() < EXCLUDE_MAX_DEF) excl_ids = {excl_ids, key};
          else excl_ovf = 1'b1;
        end
        FUNC_CAND: begin
          len = used_len();
          if (idx < len) begin
            sum = acc + longint'(val) * longint'(user_vec[idx]);
            if (sum > SCORE_HI) sum = SCORE_HI;
            if (sum < SCORE_LO) sum = SCORE_LO;
            acc = sum;
            if (idx == len - 1) begin
              if (!is_excluded(key)) rank_insert(key, acc);
              acc = 0;
            end
          end
        end
        default: begin
          queries++;
          k = (top_k_reg == 0) ? 1 : (top_k_reg > TOPK_MAX_DEF) ? TOPK_MAX_DEF : top_k_reg;
          n = (best_score.size() < k) ? best_score.size() : k;
          if (n == 0) begin
            e       = '0;
            e.ovf   = excl_ovf;
            e.last  = 1'b1;
            pending = {pending, e};
          end
          for (int r = 0; r < n; r++) begin
            e.id    = best_id[r];
            e.score = SCORE_W'(best_score[r]);
            e.rank  = RANK_W'(r);
            e.found = 1'b1;
            e.ovf   = excl_ovf;
            e.last  = (r == n - 1);
            pending = {pending, e};
          end
          clear_query();
        end
      endcase
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [KEY_W-1:0] id, logic [SCORE_W-1:0] score,
                               logic [RANK_W-1:0] rank, logic found, logic ovf,
                               logic last);
      ranked_t e;
      results++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: id 0x%0h rank %0d", id, rank);
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("result_id", e.id, id);
      check_field("result_score", 64'(e.score), 64'(score));
      check_field("rank", 64'(e.rank), 64'(rank));
      check_field("found", 64'(e.found), 64'(found));
      check_field("exclusion_overflow", 64'(e.ovf), 64'(ovf));
      check_field("last", 64'(e.last), 64'(last));
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic [1:0]                func_i = FUNC_USER;
  logic [KEY_W-1:0]          item_key_i = '0;
  logic signed [VAL_W-1:0]   element_value_i = '0;
  logic [IDX_W-1:0]          element_index_i = '0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = REG_TOP_K;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      result_valid_o;
  logic [KEY_W-1:0]          result_id_o;
  logic signed [SCORE_W-1:0] result_score_o;
  logic [RANK_W-1:0]         rank_o;
  logic                      found_o;
  logic                      exclusion_overflow_o;
  logic                      last_o;

  rank_board        board = new();
  bit               idle_on = 1'b1;
  int               cycle_count = 0;
  logic [KEY_W-1:0] key_pool [8];

  dot_product_top_k_ranker dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .func_i              (func_i),
    .item_key_i          (item_key_i),
    .element_value_i     (element_value_i),
    .element_index_i     (element_index_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .result_id_o         (result_id_o),
    .result_score_o      (result_score_o),
    .rank_o              (rank_o),
    .found_o             (found_o),
    .exclusion_overflow_o(exclusion_overflow_o),
    .last_o              (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.pending.size());
      $display("** dot_product_top_k_ranker: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      board.check_result(result_id_o, result_score_o, rank_o, found_o,
                         exclusion_overflow_o, last_o);
    end
  end

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // half the ids come from a small pool so exclusions and repeats hit
  function automatic logic [KEY_W-1:0] rand_key();
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, 7)];
    return rand64();
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(dpr_func_e f, logic [KEY_W-1:0] key,
                           logic signed [VAL_W-1:0] val, logic [IDX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    func_i          <= f;
    item_key_i      <= key;
    element_value_i <= val;
    element_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
    board.note_beat(f, key, val, idx);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] k, logic [CFG_W-1:0] vl);
    write_reg(REG_TOP_K, k);
    write_reg(REG_VLEN, vl);
  endtask

  // drop start, wait out every expected beat and any trailing scan
  task automatic settle();
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic finish_query();
    send_beat(FUNC_FINISH, rand64(), rand_val(), IDX_W'($urandom));
  endtask

  // mostly complete items, plus exclusions, vector rewrites, stray elements, finishes
  task automatic run_mix(int n_beats);
    int len;
    int sent;
    int kind;
    len  = board.used_len();
    sent = 0;
    while (sent < n_beats) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 19) != 0) begin
            send_beat(FUNC_CAND, (j == len - 1) ? rand_key() : rand64(), rand_val(),
                      IDX_W'(j));
            sent++;
          end
        end
      end else begin
        if (kind < 77) send_beat(FUNC_EXCL, rand_key(), rand_val(), IDX_W'($urandom));
        else if (kind < 82) send_beat(FUNC_USER, rand64(), rand_val(), IDX_W'($urandom));
        else if (kind < 97) send_beat(FUNC_CAND, rand_key(), rand_val(), IDX_W'($urandom));
        else finish_query();
        sent++;
      end
    end
    finish_query();
    settle();
  endtask

  initial begin
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write every user element a candidate will read
    for (int i = 0; i < USER_FILL; i++) begin
      send_beat(FUNC_USER, rand64(),
                (i == 0) ? 16'sh7FFF : (i == 1) ? 16'sh8000 : VAL_W'($urandom),
                IDX_W'(i));
    end
    send_beat(FUNC_USER, rand64(), rand_val(), 6'd62);
    send_beat(FUNC_USER, rand64(), rand_val(), 6'd63);

    // reset settings, nothing scored: empty answer
    finish_query();
    settle();

    set_config(7'd2, 7'd3);
    ka = rand64();
    kb = rand64();
    send_beat(FUNC_CAND, rand64(), 16'sh7FFF, 6'd0);
    send_beat(FUNC_CAND, rand64(), -16'sd5, 6'd9);     // past the length, ignored
    send_beat(FUNC_CAND, rand64(), 16'sh8000, 6'd1);
    send_beat(FUNC_CAND, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd100, 6'd2);
    send_beat(FUNC_EXCL, kb, 16'sd0, 6'd0);
    send_beat(FUNC_CAND, ka, 16'sd3, 6'd0);            // key of closing beat wins
    send_beat(FUNC_CAND, kb, 16'sd5, 6'd2);
    send_beat(FUNC_CAND, ka, -16'sd7, 6'd2);           // equal scores, arrival order
    send_beat(FUNC_CAND, 64'd0, -16'sd7, 6'd2);
    send_beat(FUNC_CAND, rand64(), 16'sd0, 6'd2);
    finish_query();
    settle();

    // top_k bits above the register width dropped -> 0, length 0 -> 1
    set_config(7'h60, 7'd0);
    send_beat(FUNC_CAND, ka, 16'sd1, 6'd0);
    send_beat(FUNC_CAND, kb, -16'sd1, 6'd0);
    send_beat(FUNC_CAND, rand64(), 16'sh7FFF, 6'd63);
    finish_query();
    send_beat(FUNC_EXCL, ka, 16'sd0, 6'd0);
    send_beat(FUNC_CAND, ka, 16'sh7FFF, 6'd0);
    finish_query();                                    // all excluded: empty answer
    settle();

    // length above the vector size clamps to 64
    set_config(7'd4, 7'h7F);
    send_beat(FUNC_CAND, rand64(), rand_val(), 6'd62);
    send_beat(FUNC_CAND, ka, rand_val(), 6'd63);
    finish_query();
    settle();

    // long accumulation clamps at the lower score limit
    set_config(7'd16, 7'd2);
    send_beat(FUNC_USER, rand64(), 16'sh8000, 6'd0);
    for (int i = 0; i < SAT_BEATS; i++) send_beat(FUNC_CAND, rand64(), 16'sh7FFF, 6'd0);
    send_beat(FUNC_CAND, key_pool[2], 16'sd0, 6'd1);
    finish_query();
    settle();

    // more ids than the exclusion table holds
    set_config(7'd5, 7'd2);
    for (int i = 0; i < EXCLUDE_MAX_DEF + 6; i++) begin
      send_beat(FUNC_EXCL, rand_key(), rand_val(), IDX_W'($urandom));
    end
    run_mix(20);

    idle_on = ($urandom_range(0, 1) == 0);
    set_config(7'd16, 7'd1);
    run_mix(20);
    idle_on = 1'b1;
    set_config(7'd1, 7'd5);
    run_mix(15);
    set_config(7'h1F, 7'd2);
    run_mix(15);

    idle_on = 1'b0;
    set_config(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, USER_FILL)));
    run_mix(15);

    if (board.pending.size() != 0) begin
      $error("%0d expected result beats never arrived", board.pending.size());
      board.errors++;
    end
    $display("ran %0d input beats over %0d queries, checked %0d result beats",
             board.beats, board.queries, board.results);
    $display("covered clamped and out-of-range settings, ties, exclusions, ",
             "table overflow and score saturation");
    if (board.errors == 0) begin
      $display("** dot_product_top_k_ranker: PASSED **");
    end else begin
      $display("** dot_product_top_k_ranker: FAILED **");
    end
    $finish;
  end

endmodule
